>>> hw/rtl/etse_pkg.sv
// Package for the eased tween slot engine: payload structs, command codes,
// controller state type and datapath command/status structs. No dependencies.
package etse_pkg;

   localparam int SLOTS = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_STOP  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [2:0] CURVE_IN     = 3'd1;
   localparam logic [2:0] CURVE_OUT    = 3'd2;
   localparam logic [2:0] CURVE_INOUT  = 3'd3;
   localparam logic [2:0] CURVE_BOUNCE = 3'd4;

   localparam logic KIND_REPLY  = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] from_value;
      logic signed [31:0] to_value;
      logic [15:0]        span_ms;
      logic [2:0]         curve;
      logic [3:0]         slot_index;
      logic [15:0]        step_ms;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [3:0]         slot;
      logic               accepted;
      logic signed [31:0] value;
      logic               done_res;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_ADD, ST_DIV, ST_EASE1, ST_EASE2, ST_MUL, ST_EMIT, ST_NEXT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic              take_req;   // latch request, reset scan index
      logic              do_start;   // allocate/reply
      logic              do_stop;
      logic              rd_slot;    // read slot entry into working regs
      logic              add_elapsed;
      logic              div_start;
      logic              ease1;
      logic              ease2;
      logic              mul;
      logic              emit;
      logic              next_slot;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       slot_live;
      logic       slot_last;  // scan index at last slot
      logic       div_done;
   } dp_stat_type;

endpackage

>>> hw/rtl/eased_tween_slot_engine.sv
// Top level of the eased tween slot engine.
// Depends on etse_pkg, etse_control and etse_datapath.
//
// Usage:
//   Drive req_payload and raise start while busy is low; the transfer happens
//   at that edge. Commands: start a tween, stop a slot, or tick.
//   A start or a stop keeps busy high for one cycle after the transfer, so the
//   next transfer can follow as soon as busy is low again.
//   A start gives one reply; rsp_strobe is high in the cycle after that busy
//   cycle. A stop gives no result.
//   A tick walks all slots in order: a free slot passes ST_READ and ST_NEXT, an
//   active slot ST_READ, ST_ADD, ST_DIV (waiting on the 33-step serial
//   divider), ST_EASE1, ST_EASE2, ST_MUL and ST_EMIT; each active slot gives
//   one update, strobed in the cycle after its ST_EMIT state; the final
//   update carries last.
//   Each result is on the rsp_ ports for one cycle, marked by rsp_strobe.
//   The receiver cannot stall; results are never held.
//   Reset clears all slots to free and returns the controller to idle.
module eased_tween_slot_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  etse_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output etse_pkg::rsp_type rsp_payload
);
   import etse_pkg::*;

   dp_cmd_type  ctl;
   dp_stat_type stat;

   etse_control u_ctrl (
      .clock(clock), .reset(reset), .start(start && !busy),
      .stat(stat), .ctl(ctl), .busy(busy)
   );

   etse_datapath u_dp (
      .clock(clock), .reset(reset), .req(req_payload), .ctl(ctl),
      .stat(stat), .rsp_valid(rsp_strobe), .rsp(rsp_payload)
   );
endmodule

>>> hw/rtl/etse_divider.sv
// Restoring divider: floor((elapsed << 16) / length), one quotient bit a cycle.
// No package dependency; plain arithmetic unit.
module etse_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] dividend,
   input  logic [15:0] divisor,
   output logic [16:0] quotient,
   output logic        done
);
   logic [32:0] num_ff, num_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [17:0] trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[32]} - {2'b0, divisor};
      if (start) begin
         num_in  = {dividend, 16'd0};
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[31:0], 1'b0};
         if (!trial[17]) begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], num_ff[32]};
            quo_in = {quo_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // quotient is final in the cycle that done is high
   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

>>> hw/rtl/etse_datapath.sv
// Datapath: slot table, elapsed update, divider, easing curve and interpolation.
// Depends on etse_pkg and etse_divider.
module etse_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  etse_pkg::req_type    req,
   input  etse_pkg::dp_cmd_type ctl,
   output etse_pkg::dp_stat_type stat,
   output logic                 rsp_valid,
   output etse_pkg::rsp_type    rsp
);
   import etse_pkg::*;

   logic [SLOTS-1:0] active_ff, active_in;
   logic signed [31:0] sval_mem [SLOTS];
   logic signed [31:0] eval_mem [SLOTS];
   logic [15:0]        len_mem  [SLOTS];
   logic [16:0]        ela_mem  [SLOTS];
   logic [2:0]         crv_mem  [SLOTS];

   req_type            req_ff;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   nout_ff, nout_in;
   logic signed [31:0] f_ff;
   logic signed [32:0] diff_ff;
   logic [15:0]        len_ff;
   logic [16:0]        ela_ff;
   logic [2:0]         crv_ff;
   logic [16:0]        t_ff;
   logic               done_ff;
   logic [35:0]        sq_ff;
   logic [16:0]        e_ff;
   logic signed [50:0] prod_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [16:0] quo;
   logic        div_done;
   logic [16:0] ela_sum;
   logic        free_found;
   logic [SLOT_W-1:0] free_idx;

   // divide the updated elapsed time, not the value read from the table
   etse_divider u_div (
      .clock(clock), .reset(reset), .start(ctl.div_start),
      .dividend(ela_sum), .divisor(len_ff), .quotient(quo), .done(div_done)
   );

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   assign ela_sum = ela_ff + {1'b0, req_ff.step_ms};

   // ease stage 1: select square operand
   logic [17:0] sq_sel;
   logic [16:0] u_val;
   logic [20:0] t11;
   logic [22:0] bdiff;
   always_comb begin
      u_val = 17'd65536 - t_ff;
      t11   = 21'(t_ff) * 21'd11;
      // bounce offset may go negative; square its magnitude
      if (t11 < 21'd262144)      bdiff = 23'(t11);
      else if (t11 < 21'd524288) bdiff = 23'(t11) - 23'd393216;
      else if (t11 < 21'd655360) bdiff = 23'(t11) - 23'd589824;
      else                       bdiff = {1'b0, t11, 1'b0} - 23'd1376256;
      sq_sel = '0;
      case (crv_ff)
         CURVE_IN:     sq_sel = 18'(t_ff);
         CURVE_OUT:    sq_sel = 18'(u_val);
         CURVE_INOUT:  sq_sel = (t_ff < 17'd32768) ? 18'(t_ff) : 18'(u_val);
         CURVE_BOUNCE: sq_sel = bdiff[22] ? 18'(23'd0 - bdiff) : 18'(bdiff);
         default: sq_sel = '0;
      endcase
   end

   // ease stage 2: finish e from registered square
   logic [16:0] e_sel;
   always_comb begin
      e_sel = t_ff;
      case (crv_ff)
         CURVE_IN:    e_sel = 17'(sq_ff >> 16);
         CURVE_OUT:   e_sel = 17'd65536 - 17'(sq_ff >> 16);
         CURVE_INOUT: e_sel = (t_ff < 17'd32768) ? 17'(sq_ff >> 15)
                                                 : 17'd65536 - 17'(sq_ff >> 15);
         CURVE_BOUNCE: begin
            if (t11 < 21'd262144)      e_sel = 17'(sq_ff >> 20);
            else if (t11 < 21'd524288) e_sel = 17'(sq_ff >> 20) + 17'd49152;
            else if (t11 < 21'd655360) e_sel = 17'(sq_ff >> 20) + 17'd61440;
            else                       e_sel = 17'(sq_ff >> 22) + 17'd64512;
         end
         default: e_sel = t_ff;
      endcase
   end

   logic [50:0] pabs;
   logic signed [32:0] q;
   always_comb begin
      pabs = prod_ff[50] ? 51'(-prod_ff) : 51'(prod_ff);
      if (prod_ff[50]) q = -33'(signed'({1'b0, 32'((pabs + 51'd65535) >> 16)}));
      else             q = 33'(signed'({1'b0, 32'(pabs >> 16)}));
   end

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      nout_in   = nout_ff;
      if (ctl.take_req) begin
         idx_in  = '0;
         nout_in = '0;
      end
      if (ctl.do_start && free_found) active_in[free_idx] = 1'b1;
      if (ctl.do_stop && ({28'd0, req_ff.slot_index} < 32'(SLOTS)))
         active_in[SLOT_W'(req_ff.slot_index)] = 1'b0;
      if (ctl.add_elapsed && (ela_sum >= {1'b0, len_ff})) active_in[idx_ff] = 1'b0;
      if (ctl.emit && nout_ff < CNT_W'(MAX_RESULTS)) nout_in = nout_ff + 1'b1;
      if (ctl.next_slot) idx_in = idx_ff + 1'b1;
   end

   // last update: no active slot after this one
   logic later_live;
   always_comb begin
      later_live = 1'b0;
      for (int i = 0; i < SLOTS; i++)
         if (SLOT_W'(i) > idx_ff && active_ff[i]) later_live = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (ctl.take_req) req_ff <= req;
      if (ctl.do_start && free_found) begin
         sval_mem[free_idx] <= req_ff.from_value;
         eval_mem[free_idx] <= req_ff.to_value;
         len_mem[free_idx]  <= req_ff.span_ms;
         ela_mem[free_idx]  <= '0;
         crv_mem[free_idx]  <= req_ff.curve;
      end
      if (ctl.rd_slot) begin
         f_ff    <= sval_mem[idx_ff];
         diff_ff <= 33'(eval_mem[idx_ff]) - 33'(sval_mem[idx_ff]);
         len_ff  <= len_mem[idx_ff];
         ela_ff  <= ela_mem[idx_ff];
         crv_ff  <= crv_mem[idx_ff];
      end
      if (ctl.add_elapsed) begin
         ela_ff            <= ela_sum;
         ela_mem[idx_ff]   <= ela_sum;
         done_ff           <= ela_sum >= {1'b0, len_ff};
         if (ela_sum >= {1'b0, len_ff}) t_ff <= 17'd65536;
      end
      if (div_done && !done_ff) t_ff <= quo;
      if (ctl.ease1) sq_ff <= sq_sel * sq_sel;
      if (ctl.ease2) e_ff <= e_sel;
      if (ctl.mul) prod_ff <= 51'(diff_ff) * 51'(signed'({1'b0, e_ff}));
      if (ctl.do_start) begin
         rsp_ff.kind     <= KIND_REPLY;
         rsp_ff.slot     <= free_found ? 4'(free_idx) : 4'd0;
         rsp_ff.accepted <= free_found;
         rsp_ff.value    <= '0;
         rsp_ff.done_res <= 1'b0;
         rsp_ff.last     <= 1'b1;
      end
      if (ctl.emit && nout_ff < CNT_W'(MAX_RESULTS)) begin
         rsp_ff.kind     <= KIND_UPDATE;
         rsp_ff.slot     <= 4'(idx_ff);
         rsp_ff.accepted <= 1'b0;
         rsp_ff.value    <= 32'(33'(f_ff) + q);
         rsp_ff.done_res <= done_ff;
         rsp_ff.last     <= !later_live || (nout_ff == CNT_W'(MAX_RESULTS - 1));
      end
      if (reset) begin
         active_ff    <= '0;
         idx_ff       <= '0;
         nout_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         nout_ff      <= nout_in;
         rsp_valid_ff <= ctl.do_start || (ctl.emit && nout_ff < CNT_W'(MAX_RESULTS));
      end
   end

   assign stat.cmd       = req_ff.cmd;
   assign stat.slot_live = active_ff[idx_ff];
   assign stat.slot_last = (idx_ff == SLOT_W'(SLOTS - 1));
   assign stat.div_done  = div_done;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp            = rsp_ff;
endmodule

>>> hw/rtl/etse_control.sv
// Controller state machine: sequences start, stop and the per-slot tick walk.
// Depends on etse_pkg.
module etse_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  etse_pkg::dp_stat_type stat,
   output etse_pkg::dp_cmd_type  ctl,
   output logic                  busy
);
   import etse_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_READ;
         ST_READ: begin
            if (stat.cmd == CMD_TICK) begin
               state_in = stat.slot_live ? ST_ADD : ST_NEXT;
            end else state_in = ST_IDLE;
         end
         ST_ADD:   state_in = ST_DIV;
         ST_DIV:   if (stat.div_done) state_in = ST_EASE1;
         ST_EASE1: state_in = ST_EASE2;
         ST_EASE2: state_in = ST_MUL;
         ST_MUL:   state_in = ST_EMIT;
         // emit already advances the scan index
         ST_EMIT:  state_in = stat.slot_last ? ST_IDLE : ST_READ;
         ST_NEXT:  state_in = stat.slot_last ? ST_IDLE : ST_READ;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_IDLE: ctl.take_req = start;
         ST_READ: begin
            ctl.do_start = (stat.cmd == CMD_START);
            ctl.do_stop  = (stat.cmd == CMD_STOP);
            ctl.rd_slot  = (stat.cmd == CMD_TICK);
         end
         ST_ADD:   ctl.add_elapsed = 1'b1;
         ST_DIV:   ctl.ease1 = 1'b0;
         ST_EASE1: ctl.ease1 = 1'b1;
         ST_EASE2: ctl.ease2 = 1'b1;
         ST_MUL:   ctl.mul = 1'b1;
         ST_EMIT:  begin
            ctl.emit      = 1'b1;
            ctl.next_slot = !stat.slot_last;
         end
         ST_NEXT:  ctl.next_slot = !stat.slot_last;
         default:  ctl = '0;
      endcase
      ctl.div_start = (state_ff == ST_ADD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

>>> hw/rtl/etse_checker.sv
// Port-level checker for the eased tween slot engine, bound to the top level.
// Depends on etse_pkg.
module etse_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input etse_pkg::req_type req_payload,
   input logic              rsp_strobe,
   input etse_pkg::rsp_type rsp_payload
);
   import etse_pkg::*;

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised after transfer");

   a_reply_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.kind == KIND_REPLY) |->
      (rsp_payload.last && rsp_payload.value == 32'sd0 && !rsp_payload.done_res))
      else $error("bad start reply");

   a_update_no_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.kind == KIND_UPDATE) |-> !rsp_payload.accepted)
      else $error("update with accepted set");

   a_start_reply: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.cmd == CMD_START) |=> ##1
      (rsp_strobe && rsp_payload.kind == KIND_REPLY))
      else $error("missing start reply");
endmodule

bind eased_tween_slot_engine etse_checker u_chk (.*);
